FILE: hdl/otm_pkg.sv
// shared types, codes and constants of the ordered alarm timer manager
package otm_pkg;

    // default number of timer slots
    localparam int NUM_TIMERS_DEF = 16;
    // most expiries one tick may report
    localparam int MAX_OUT = 16;

    localparam int OP_W    = 3;
    localparam int ID_W    = 4;
    localparam int PER_W   = 32;
    localparam int KIND_W  = 2;
    localparam int TIME_W  = 64;

    // operation codes
    localparam logic [OP_W-1:0] OP_CONFIG = 3'd0;
    localparam logic [OP_W-1:0] OP_START  = 3'd1;
    localparam logic [OP_W-1:0] OP_STOP   = 3'd2;
    localparam logic [OP_W-1:0] OP_READ   = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IDLE_TICK = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [ID_W-1:0]  timer_id;
        logic [PER_W-1:0] period;
        logic             periodic_mode;
    } otm_cmd_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ID_W-1:0]   result_timer;
        logic              command_ok;
        logic [PER_W-1:0]  period_value;
        logic              last_result;
    } otm_res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT_UP,
        S_FIND,
        S_SHIFT_DOWN,
        S_REARM,
        S_TICK_CHECK,
        S_STATUS
    } otm_state_t;

endpackage

FILE: hdl/otm_chan_if.sv
// valid/ready channel carrying one payload beat
interface otm_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/ordered_alarm_timer_manager.sv
// ordered alarm timer manager: timer table, deadline-ordered list and its sequencer
//
//   channel | dir | payload    | beat
//   --------+-----+------------+------------------------------------------
//   cmd     | in  | otm_cmd_t  | one command or tick
//   res     | out | otm_res_t  | one status, expiry or empty-tick result
//
// configure, read, failed start and stop of an idle timer give their status
// without walking the list; start and stop walk the list through its single
// read port; a tick walks the list per expiry (shift out of the head, and for
// a periodic timer a re-insert scan and shift), all set by the one list read
// port and the shared 64-bit adder and comparator
// reset clears time, the timer table and the list count; list entries are
// never read above the count, so there is no clearing pass
// the result register holds one beat; while it is full the sequencer waits for
// res.ready, and a new command is taken once idle even while a result still waits
module ordered_alarm_timer_manager #(
    parameter int NUM_TIMERS = otm_pkg::NUM_TIMERS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    otm_chan_if.sink        cmd,
    otm_chan_if.source      res
);
    import otm_pkg::*;

    // index, count and emit-counter widths
    localparam int IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int CW = $clog2(NUM_TIMERS + 1);
    localparam int NW = $clog2(MAX_OUT + 1);

    // sequencer state
    otm_state_t state_reg, state_next;

    // time and timer table
    logic [TIME_W-1:0]     time_now_reg, time_now_next;
    logic [PER_W-1:0]      period_reg [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] periodic_reg;
    logic [NUM_TIMERS-1:0] active_reg;

    // ordered list, valid below the count only
    logic [IW-1:0]         list_slot_reg [NUM_TIMERS];
    logic [TIME_W-1:0]     list_dl_reg [NUM_TIMERS];
    logic [CW-1:0]         count_reg, count_next;

    // latched command
    logic [OP_W-1:0]       op_reg, op_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [PER_W-1:0]      per_in_reg, per_in_next;
    logic                  mode_in_reg, mode_in_next;

    // working registers
    logic [IW-1:0]         slot_reg, slot_next;
    logic [TIME_W-1:0]     dl_reg, dl_next;
    logic [CW-1:0]         pos_reg, pos_next;
    logic [CW-1:0]         k_reg, k_next;
    logic [NW-1:0]         n_reg, n_next;
    logic [NUM_TIMERS-1:0] fired_reg, fired_next;
    logic                  tick_reg, tick_next;
    logic                  ok_reg, ok_next;
    logic [PER_W-1:0]      rd_val_reg, rd_val_next;

    // result register
    logic                  out_valid_reg;
    otm_res_t              out_data_reg;
    logic                  out_load;
    otm_res_t              out_data_next;
    logic                  out_free;

    // table and list write strobes
    logic                  cfg_we;
    logic                  act_we;
    logic                  act_val;
    logic                  list_we;
    logic [IW-1:0]         wr_idx;
    logic [IW-1:0]         wr_slot;
    logic [TIME_W-1:0]     wr_dl;

    // single list read port
    logic [IW-1:0]         rd_idx;
    logic [IW-1:0]         rd_slot;
    logic [TIME_W-1:0]     rd_dl;

    // shared adder and comparator
    logic [PER_W-1:0]      period_rd;
    logic [TIME_W-1:0]     add_b;
    logic [TIME_W-1:0]     add_sum;
    logic [TIME_W-1:0]     cmp_b;
    logic                  cmp_le;

    logic                  id_ok;
    logic                  due;
    logic                  emit;
    logic [CW-1:0]         k_up;
    logic [CW-1:0]         k_dn;

    assign cmd.ready = (state_reg == S_IDLE);
    assign res.valid = out_valid_reg;
    assign res.data  = out_data_reg;
    assign out_free  = !out_valid_reg || res.ready;

    assign id_ok = (int'(id_reg) < NUM_TIMERS);
    assign k_up  = CW'(k_reg + 1'b1);
    assign k_dn  = CW'(k_reg - 1'b1);

    // read address follows the walk
    always_comb
    begin
        case (state_reg)
            S_SCAN, S_FIND: rd_idx = pos_reg[IW-1:0];
            S_SHIFT_UP:     rd_idx = k_dn[IW-1:0];
            S_SHIFT_DOWN:   rd_idx = k_up[IW-1:0];
            default:        rd_idx = '0;
        endcase
    end

    assign rd_slot   = list_slot_reg[rd_idx];
    assign rd_dl     = list_dl_reg[rd_idx];
    assign period_rd = period_reg[slot_reg];

    // one 64-bit adder: time + 1 on a tick, time + period otherwise
    assign add_b   = (state_reg == S_DECODE && op_reg == OP_TICK) ? TIME_W'(1)
                                                                  : TIME_W'(period_rd);
    assign add_sum = time_now_reg + add_b;

    // one 64-bit comparator: head against time, or entry against new deadline
    assign cmp_b  = (state_reg == S_TICK_CHECK) ? time_now_reg : dl_reg;
    assign cmp_le = (rd_dl <= cmp_b);

    // head may pop: room left, list not empty, due, not yet fired this tick
    assign due  = (int'(n_reg) < MAX_OUT) && (count_reg != '0) && cmp_le
                  && !fired_reg[rd_slot];
    assign emit = (n_reg != '0) || !due;

    always_comb
    begin
        state_next    = state_reg;
        time_now_next = time_now_reg;
        count_next    = count_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        per_in_next   = per_in_reg;
        mode_in_next  = mode_in_reg;
        slot_next     = slot_reg;
        dl_next       = dl_reg;
        pos_next      = pos_reg;
        k_next        = k_reg;
        n_next        = n_reg;
        fired_next    = fired_reg;
        tick_next     = tick_reg;
        ok_next       = ok_reg;
        rd_val_next   = rd_val_reg;
        cfg_we        = 1'b0;
        act_we        = 1'b0;
        act_val       = 1'b0;
        list_we       = 1'b0;
        wr_idx        = '0;
        wr_slot       = slot_reg;
        wr_dl         = dl_reg;
        out_load      = 1'b0;
        out_data_next = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next      = cmd.data.operation;
                    id_next      = cmd.data.timer_id;
                    per_in_next  = cmd.data.period;
                    mode_in_next = cmd.data.periodic_mode;
                    slot_next    = IW'(cmd.data.timer_id);
                    state_next   = S_DECODE;
                end
            end

            S_DECODE:
            begin
                tick_next   = 1'b0;
                ok_next     = 1'b1;
                rd_val_next = '0;
                state_next  = S_STATUS;
                if (op_reg == OP_TICK)
                begin
                    time_now_next = add_sum;
                    n_next        = '0;
                    fired_next    = '0;
                    state_next    = S_TICK_CHECK;
                end
                else if (!id_ok)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    case (op_reg)
                        OP_CONFIG:
                        begin
                            cfg_we = 1'b1;
                        end
                        OP_START:
                        begin
                            if (active_reg[slot_reg])
                            begin
                                ok_next = 1'b0;
                            end
                            else
                            begin
                                act_we   = 1'b1;
                                act_val  = 1'b1;
                                dl_next  = add_sum;
                                pos_next = '0;
                                if (int'(count_reg) < NUM_TIMERS)
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        OP_STOP:
                        begin
                            if (active_reg[slot_reg])
                            begin
                                act_we     = 1'b1;
                                act_val    = 1'b0;
                                pos_next   = '0;
                                state_next = S_FIND;
                            end
                        end
                        OP_READ:
                        begin
                            rd_val_next = period_rd;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // insert after equal deadlines
                if (pos_reg < count_reg && cmp_le)
                begin
                    pos_next = CW'(pos_reg + 1'b1);
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = S_SHIFT_UP;
                end
            end

            S_SHIFT_UP:
            begin
                list_we = 1'b1;
                if (k_reg > pos_reg)
                begin
                    wr_idx  = k_reg[IW-1:0];
                    wr_slot = rd_slot;
                    wr_dl   = rd_dl;
                    k_next  = k_dn;
                end
                else
                begin
                    wr_idx     = pos_reg[IW-1:0];
                    count_next = CW'(count_reg + 1'b1);
                    state_next = tick_reg ? S_TICK_CHECK : S_STATUS;
                end
            end

            S_FIND:
            begin
                if (pos_reg < count_reg)
                begin
                    if (rd_slot == slot_reg)
                    begin
                        k_next     = pos_reg;
                        state_next = S_SHIFT_DOWN;
                    end
                    else
                    begin
                        pos_next = CW'(pos_reg + 1'b1);
                    end
                end
                else
                begin
                    state_next = S_STATUS;
                end
            end

            S_SHIFT_DOWN:
            begin
                if (k_up < count_reg)
                begin
                    list_we = 1'b1;
                    wr_idx  = k_reg[IW-1:0];
                    wr_slot = rd_slot;
                    wr_dl   = rd_dl;
                    k_next  = k_up;
                end
                else
                begin
                    count_next = CW'(count_reg - 1'b1);
                    state_next = tick_reg ? S_REARM : S_STATUS;
                end
            end

            S_REARM:
            begin
                if (periodic_reg[slot_reg])
                begin
                    dl_next    = add_sum;
                    pos_next   = '0;
                    state_next = S_SCAN;
                end
                else
                begin
                    act_we     = 1'b1;
                    act_val    = 1'b0;
                    state_next = S_TICK_CHECK;
                end
            end

            S_TICK_CHECK:
            begin
                // the previous expiry is sent once it is known whether another follows
                if (!(emit && !out_free))
                begin
                    if (emit)
                    begin
                        out_load = 1'b1;
                        if (n_reg != '0)
                        begin
                            out_data_next.result_kind  = KIND_EXPIRY;
                            out_data_next.result_timer = ID_W'(slot_reg);
                            out_data_next.last_result  = !due;
                        end
                        else
                        begin
                            out_data_next.result_kind = KIND_IDLE_TICK;
                            out_data_next.last_result = 1'b1;
                        end
                    end
                    if (due)
                    begin
                        slot_next           = rd_slot;
                        fired_next[rd_slot] = 1'b1;
                        n_next              = NW'(n_reg + 1'b1);
                        k_next              = '0;
                        tick_next           = 1'b1;
                        state_next          = S_SHIFT_DOWN;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_STATUS:
            begin
                if (out_free)
                begin
                    out_load                   = 1'b1;
                    out_data_next.result_kind  = KIND_STATUS;
                    out_data_next.result_timer = id_reg;
                    out_data_next.command_ok   = ok_reg;
                    out_data_next.period_value = rd_val_reg;
                    out_data_next.last_result  = 1'b1;
                    state_next                 = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            time_now_reg  <= '0;
            count_reg     <= '0;
            periodic_reg  <= '0;
            active_reg    <= '0;
            n_reg         <= '0;
            fired_reg     <= '0;
            tick_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TIMERS; i++)
            begin
                period_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            time_now_reg <= time_now_next;
            count_reg    <= count_next;
            n_reg        <= n_next;
            fired_reg    <= fired_next;
            tick_reg     <= tick_next;
            if (cfg_we)
            begin
                period_reg[slot_reg]   <= per_in_reg;
                periodic_reg[slot_reg] <= mode_in_reg;
            end
            if (act_we)
            begin
                active_reg[slot_reg] <= act_val;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and list entries
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        id_reg      <= id_next;
        per_in_reg  <= per_in_next;
        mode_in_reg <= mode_in_next;
        slot_reg    <= slot_next;
        dl_reg      <= dl_next;
        pos_reg     <= pos_next;
        k_reg       <= k_next;
        ok_reg      <= ok_next;
        rd_val_reg  <= rd_val_next;
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
        if (list_we)
        begin
            list_slot_reg[wr_idx] <= wr_slot;
            list_dl_reg[wr_idx]   <= wr_dl;
        end
    end

`ifndef SYNTH
    // list never holds more entries than slots
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= NUM_TIMERS)
        else $error("list count above slot count");

    // between items the number of active timers equals the list count
    a_active_matches_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(active_reg) == int'(count_reg)))
        else $error("active timers and list count disagree");

    // one tick never reports more expiries than allowed
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(n_reg) <= MAX_OUT)
        else $error("too many expiries in one tick");

    // a tick advances time by exactly one
    a_tick_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.data.operation == OP_TICK)
        |=> ##1 (time_now_reg == $past(time_now_reg, 2) + TIME_W'(1)))
        else $error("tick did not advance time by one");
`endif

endmodule
